// File: sv/cr2r_pkg.sv
package cr2r_pkg;

   localparam int OP_LEN_BITS = 28;
   localparam logic [OP_LEN_BITS-1:0] LEN_MAX = {OP_LEN_BITS{1'b1}};

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_M    = 8'h4D;
   localparam logic [7:0] CH_N    = 8'h4E;
   localparam logic [7:0] CH_I    = 8'h49;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_X    = 8'h58;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_XOP = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic [7:0]  cigar_char;
      logic        first_byte;
      logic        last_byte;
      logic [30:0] align_start;
      logic [30:0] query_loc;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] ref_pos;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [OP_LEN_BITS-1:0] length_accum;
      logic                   digits_frozen;
      logic [31:0]            read_offset;
      logic [31:0]            ref_offset;
      logic [30:0]            start_latch;
      logic [30:0]            loc_latch;
      logic                   hit_flag;
      logic [31:0]            hit_pos;
      logic [1:0]             status_reg;
   } state_type;

endpackage

// File: sv/cr2r_step.sv
module cr2r_step (
   input  cr2r_pkg::state_type state_cur,
   input  cr2r_pkg::req_type   req,
   output cr2r_pkg::state_type state_nxt,
   output cr2r_pkg::rsp_type   rsp
);

   localparam int L = cr2r_pkg::OP_LEN_BITS;

   cr2r_pkg::state_type base;
   cr2r_pkg::state_type nxt;
   logic                is_digit;
   logic [L+3:0]        acc_v;
   logic                acc_ovf;
   logic [32:0]         len33;
   logic [32:0]         rd_sum;
   logic [32:0]         rf_sum;
   logic                hit;
   logic [31:0]         loc_span;
   logic [33:0]         pos;
   logic                sat;

   always_comb begin
      base = state_cur;
      if (req.first_byte) begin
         base = '0;
         base.start_latch = req.align_start;
         base.loc_latch = req.query_loc;
      end
   end

   assign is_digit = (req.cigar_char >= cr2r_pkg::CH_ZERO) &&
                     (req.cigar_char <= cr2r_pkg::CH_NINE);

   assign acc_v = {1'b0, base.length_accum, 3'b000} + {3'b000, base.length_accum, 1'b0}
                + {{(L){1'b0}}, 4'(req.cigar_char - cr2r_pkg::CH_ZERO)};
   assign acc_ovf = (acc_v[L+3:L] != 4'd0);

   assign len33  = {{(33-L){1'b0}}, base.length_accum};
   assign rd_sum = {1'b0, base.read_offset} + len33;
   assign rf_sum = {1'b0, base.ref_offset} + len33;

   assign hit = !base.hit_flag && (base.length_accum != '0) &&
                ({1'b0, base.loc_latch} > base.read_offset) &&
                ({2'b00, base.loc_latch} <= rd_sum);
   assign loc_span = {1'b0, base.loc_latch} - base.read_offset - 32'd1;
   assign pos  = {3'b000, base.start_latch} + {2'b00, base.ref_offset} + {2'b00, loc_span};

   always_comb begin
      nxt = base;
      sat = 1'b0;
      if (is_digit) begin
         if (!base.digits_frozen) begin
            nxt.length_accum = acc_ovf ? cr2r_pkg::LEN_MAX : acc_v[L-1:0];
            sat = acc_ovf;
         end
      end else begin
         case (req.cigar_char)
            cr2r_pkg::CH_M: begin
               nxt.length_accum = '0;
               nxt.digits_frozen = 1'b0;
               if (hit) begin
                  nxt.hit_flag = 1'b1;
                  nxt.hit_pos = (pos[33:32] != 2'd0) ? 32'hFFFF_FFFF : pos[31:0];
               end
               nxt.read_offset = rd_sum[32] ? 32'hFFFF_FFFF : rd_sum[31:0];
               nxt.ref_offset = rf_sum[32] ? 32'hFFFF_FFFF : rf_sum[31:0];
               sat = (hit && (pos[33:32] != 2'd0)) || rd_sum[32] || rf_sum[32];
            end
            cr2r_pkg::CH_S, cr2r_pkg::CH_I: begin
               nxt.length_accum = '0;
               nxt.digits_frozen = 1'b0;
               nxt.read_offset = rd_sum[32] ? 32'hFFFF_FFFF : rd_sum[31:0];
               sat = rd_sum[32];
            end
            cr2r_pkg::CH_D, cr2r_pkg::CH_N: begin
               nxt.length_accum = '0;
               nxt.digits_frozen = 1'b0;
               nxt.ref_offset = rf_sum[32] ? 32'hFFFF_FFFF : rf_sum[31:0];
               sat = rf_sum[32];
            end
            cr2r_pkg::CH_X: begin
               nxt.length_accum = '0;
               nxt.digits_frozen = 1'b0;
               nxt.status_reg = cr2r_pkg::ST_XOP;
            end
            default: begin
               nxt.digits_frozen = 1'b1;
            end
         endcase
      end
      if (sat && (nxt.status_reg == cr2r_pkg::ST_OK)) begin
         nxt.status_reg = cr2r_pkg::ST_SAT;
      end
   end

   assign state_nxt   = nxt;
   assign rsp.found   = nxt.hit_flag && (nxt.status_reg != cr2r_pkg::ST_XOP);
   assign rsp.ref_pos = rsp.found ? nxt.hit_pos : 32'd0;
   assign rsp.status  = nxt.status_reg;

endmodule

// File: sv/cigar_read_to_reference_position.sv
// Flow: a request is registered in req_ff, then decoded by cr2r_step into state_ff; a
// result from a last byte is registered in rsp_ff and presented on rsp_valid.
// Throughput: one byte per cycle, set by the state update loop; a last byte waits while a held result is stalled.
// Reset: synchronous, active high; clears the parse state and both valid flags.
// A request with first_byte set restarts the parse for a new read.
module cigar_read_to_reference_position (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cr2r_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cr2r_pkg::rsp_type rsp_payload
);

   logic                req_valid_ff;
   logic                req_valid_in;
   cr2r_pkg::req_type   req_ff;
   cr2r_pkg::state_type state_ff;
   cr2r_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cr2r_pkg::rsp_type   rsp_ff;
   cr2r_pkg::rsp_type   rsp_in;
   logic                out_free;
   logic                step_go;

   cr2r_step u_step (
      .state_cur (state_ff),
      .req       (req_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = req_valid_ff && (!req_ff.last_byte || out_free);
   assign req_stall = req_valid_ff && !step_go;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step_go && req_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
      if (step_go && req_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
